// ----- design/hcd_pkg.sv -----
// Shared types, constants and helpers for the HTTP chunked body decoder.
package hcd_pkg;

   localparam int SIZE_WIDTH = 32;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;

   typedef enum logic [6:0] {
      PH_SIZE    = 7'b0000001,
      PH_SIZE_LF = 7'b0000010,
      PH_DATA    = 7'b0000100,
      PH_SEP_CR  = 7'b0001000,
      PH_SEP_LF  = 7'b0010000,
      PH_DONE    = 7'b0100000,
      PH_ERR     = 7'b1000000
   } phase_type;

   typedef struct packed {
      phase_type               phase;
      logic [SIZE_WIDTH-1:0]   count;
      logic                    digit_seen;
   } state_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic       done_res;
      logic       error;
   } result_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_type;

   // Decodes one ASCII hex digit, upper or lower case.
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.is_hex = 1'b1;
      h.value  = 4'd0;
      if (c inside {[CH_0:CH_9]}) begin
         h.value = 4'(c - CH_0);
      end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
         h.value = 4'(c - CH_UPPER_A + 8'd10);
      end else if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
         h.value = 4'(c - CH_LOWER_A + 8'd10);
      end else begin
         h.is_hex = 1'b0;
      end
      return h;
   endfunction

endpackage

// ----- design/http_chunked_decoder.sv -----
// Top level of the HTTP chunked transfer decoder.
// Usage: raw body bytes enter on the req_ channel, one byte per transfer.
// Every accepted byte yields exactly one transfer on the rsp_ channel that
// carries the payload byte (zero unless rsp_payload_valid), the done flag
// of the zero-size final chunk and the sticky error flag.
// Latency: the result of a byte is presented in the cycle after its
// transfer, from the result register.
// Throughput: one byte per cycle while the receiver keeps rsp_ready high; the decoder state is updated in the same
// cycle a byte is taken, so consecutive bytes need no gap.
// Stalls: req_ready is high whenever the result register is empty or is
// being drained in the same cycle, so a stalled receiver holds back the
// input after one result is buffered, and no result is lost or repeated.
// Reset (synchronous, active high) returns the decoder to reading chunk
// size digits with a zero count and empties the result register.
// Once done or error is set, later bytes are accepted and answered with
// unchanged flags and no payload.
module http_chunked_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_payload_valid,
   output logic       rsp_done_res,
   output logic       rsp_error
);
   import hcd_pkg::*;

   state_type  state_ff, state_in;
   result_type res_ff, res_in;
   logic       valid_ff;
   logic       accept;

   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   hcd_core u_core (
      .cur     (state_ff),
      .in_byte (req_in_byte),
      .nxt     (state_in),
      .res     (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PH_SIZE;
         state_ff.count      <= '0;
         state_ff.digit_seen <= 1'b0;
         valid_ff            <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // The result payload needs no reset; it is qualified by valid_ff.
   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_payload_byte  = res_ff.payload_byte;
   assign rsp_payload_valid = res_ff.payload_valid;
   assign rsp_done_res      = res_ff.done_res;
   assign rsp_error         = res_ff.error;

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff.phase))
      else $error("decoder phase is not one-hot");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_ERR |=> state_ff.phase == PH_ERR)
      else $error("error phase was left without reset");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_DONE |=> state_ff.phase == PH_DONE)
      else $error("done phase was left without reset");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_valid |-> !rsp_done_res && !rsp_error)
      else $error("payload byte reported together with done or error");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_done_res && rsp_error))
      else $error("done and error both set");

endmodule

// ----- design/hcd_core.sv -----
// Next-state and result logic of the chunked decoder for one input byte.
module hcd_core (
   input  hcd_pkg::state_type  cur,
   input  logic [7:0]          in_byte,
   output hcd_pkg::state_type  nxt,
   output hcd_pkg::result_type res
);
   import hcd_pkg::*;

   hex_type               hex;
   logic [SIZE_WIDTH-1:0] count_dec;
   logic                  valid;

   assign hex       = hex_decode(in_byte);
   assign count_dec = cur.count - SIZE_WIDTH'(1);

   always_comb begin
      nxt   = cur;
      valid = 1'b0;
      case (cur.phase)
         PH_SIZE: begin
            if (in_byte == CH_CR) begin
               nxt.phase = PH_SIZE_LF;
            end else if (hex.is_hex) begin
               nxt.count      = {cur.count[SIZE_WIDTH-5:0], hex.value};
               nxt.digit_seen = 1'b1;
            end else begin
               nxt.phase = PH_ERR;
            end
         end
         PH_SIZE_LF: begin
            if (in_byte == CH_LF && cur.digit_seen) begin
               nxt.digit_seen = 1'b0;
               nxt.phase = (cur.count == '0) ? PH_DONE : PH_DATA;
            end else begin
               nxt.phase = PH_ERR;
            end
         end
         PH_DATA: begin
            valid     = 1'b1;
            nxt.count = count_dec;
            if (count_dec == '0) begin
               nxt.phase = PH_SEP_CR;
            end
         end
         PH_SEP_CR: nxt.phase = (in_byte == CH_CR) ? PH_SEP_LF : PH_ERR;
         PH_SEP_LF: nxt.phase = (in_byte == CH_LF) ? PH_SIZE : PH_ERR;
         PH_DONE: begin
         end
         default: nxt.phase = PH_ERR;
      endcase
   end

   assign res.payload_byte  = valid ? in_byte : 8'd0;
   assign res.payload_valid = valid;
   assign res.done_res      = (nxt.phase == PH_DONE);
   assign res.error         = (nxt.phase == PH_ERR);

endmodule
